>>> hdl/scq_pkg.sv
package scq_pkg;

  localparam int unsigned ScaleW    = 17;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned DelayW    = 42;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ProdW     = DelayW + ScaleW;
  localparam int unsigned DeadW     = TimeW + 1;
  localparam int unsigned HalfW     = DelayW / 2;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CountW    = 5;
  localparam logic [ScaleW-1:0] ScaleOne = ScaleW'(65536);
  localparam logic [9:0] UsPerMs = 10'd1000;

  localparam logic [CmdW-1:0] CmdArmUs = 2'd0;
  localparam logic [CmdW-1:0] CmdArmMs = 2'd1;
  localparam logic [CmdW-1:0] CmdDisarm = 2'd2;
  localparam logic [CmdW-1:0] CmdTick  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WRITE  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_WAIT   = 5'b10000
  } scq_state_e;

  typedef struct packed {
    logic capture;
    logic write;
    logic scan_start;
    logic take_due;
    logic out_load;
    logic out_final;
  } scq_ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic due;
    logic pend_valid;
    logic out_free;
  } scq_stat_t;

endpackage

>>> hdl/scq_ram.sv
module scq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/scq_ctrl.sv
module scq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scq_pkg::scq_stat_t stat_i,
  output scq_pkg::scq_ctrl_t ctrl_o
);
  import scq_pkg::*;

  scq_state_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic more;
  logic need_out;

  assign in_stall_o = (state_q != S_IDLE);
  assign more = stat_i.is_tick && stat_i.due && (count_q < CountW'(MaxResults));
  assign need_out = !more || stat_i.pend_valid;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ctrl_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          count_d = '0;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ctrl_o.write = 1'b1;
        ctrl_o.scan_start = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE, S_WAIT: begin
        if (!need_out || stat_i.out_free) begin
          ctrl_o.out_load = need_out;
          if (more) begin
            ctrl_o.take_due = 1'b1;
            ctrl_o.scan_start = 1'b1;
            count_d = count_q + 1'b1;
            state_d = S_SCAN;
          end else begin
            ctrl_o.out_final = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_WAIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxResults)) else $error("emit count overflow");
  a_capture_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> state_q == S_WRITE) else $error("capture not followed by write");
  a_take_needs_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.take_due |-> stat_i.due && stat_i.is_tick) else $error("take without due slot");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_final |=> state_q == S_IDLE) else $error("final word not closing item");

endmodule

>>> hdl/scq_dp.sv
module scq_dp #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  scq_pkg::scq_ctrl_t             ctrl_i,
  output scq_pkg::scq_stat_t             stat_o,
  input  logic [scq_pkg::ScaleW-1:0]     scale_i,
  input  logic [scq_pkg::CmdW-1:0]       cmd_i,
  input  logic [scq_pkg::SlotW-1:0]      slot_i,
  input  logic [scq_pkg::ValueW-1:0]     delay_value_i,
  input  logic [scq_pkg::TimeW-1:0]      now_us_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           expired_valid_o,
  output logic [scq_pkg::SlotW-1:0]      expired_slot_o,
  output logic                           last_o,
  output logic                           next_valid_o,
  output logic [scq_pkg::DelayW-1:0]     next_delay_us_o
);
  import scq_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned ExtW = IdxW + SlotW;
  localparam int unsigned RamW = TimeW + DelayW;

  logic [CmdW-1:0]   cmd_q;
  logic [SlotW-1:0]  slot_q;
  logic [ValueW-1:0] value_q;
  logic [TimeW-1:0]  now_q;

  logic [ExtW-1:0]   slot_ext;
  logic              slot_ok;
  logic [IdxW-1:0]   slot_idx;
  logic              is_arm;
  logic [DelayW-1:0] delay_w;
  logic [NUM_TIMERS-1:0] armed_q;

  logic            run_q;
  logic [IdxW-1:0] cnt_q;
  logic            v1_q, v2_q, v3_q, v4_q;
  logic            a1_q, a2_q, a3_q, a4_q;
  logic [IdxW-1:0] i1_q, i2_q, i3_q, i4_q;
  logic [RamW-1:0] rdata;
  logic [TimeW-1:0] st2_q, st3_q;
  logic [HalfW+ScaleW-1:0] plo_q, phi_q;
  logic [ProdW-1:0] prod3_q;
  logic [DeadW-1:0] dl4_q;

  logic            min_valid_q;
  logic [DeadW-1:0] min_dl_q;
  logic [IdxW-1:0] min_idx_q;
  logic            pend_valid_q;
  logic [IdxW-1:0] pend_idx_q;
  logic [ExtW-1:0] pend_ext;
  logic [DeadW-1:0] diff;
  logic [DelayW-1:0] next_delay;

  logic out_valid_q;
  logic out_free;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      slot_q <= slot_i;
      value_q <= delay_value_i;
      now_q <= now_us_i;
    end
  end

  assign slot_ext = ExtW'(slot_q);
  assign slot_ok = slot_ext < ExtW'(NUM_TIMERS);
  assign slot_idx = slot_ext[IdxW-1:0];
  assign is_arm = (cmd_q == CmdArmUs) || (cmd_q == CmdArmMs);
  assign delay_w = (cmd_q == CmdArmMs) ? DelayW'(value_q) * DelayW'(UsPerMs) :
                                         DelayW'(value_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (ctrl_i.write && slot_ok && is_arm) begin
      armed_q[slot_idx] <= 1'b1;
    end else if (ctrl_i.write && slot_ok && (cmd_q == CmdDisarm)) begin
      armed_q[slot_idx] <= 1'b0;
    end else if (ctrl_i.take_due) begin
      armed_q[min_idx_q] <= 1'b0;
    end
  end

  scq_ram #(.Width(RamW), .Depth(NUM_TIMERS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.write && slot_ok && is_arm),
    .waddr_i (slot_idx),
    .wdata_i ({now_q, delay_w}),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ctrl_i.scan_start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == IdxW'(NUM_TIMERS - 1)) begin
          run_q <= 1'b0;
        end
      end
      v1_q <= run_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= cnt_q;
    a1_q <= armed_q[cnt_q];
    i2_q <= i1_q;
    a2_q <= a1_q;
    st2_q <= rdata[RamW-1:DelayW];
    plo_q <= rdata[HalfW-1:0] * scale_i;
    phi_q <= rdata[DelayW-1:HalfW] * scale_i;
    i3_q <= i2_q;
    a3_q <= a2_q;
    st3_q <= st2_q;
    prod3_q <= (ProdW'(phi_q) << HalfW) + ProdW'(plo_q);
    i4_q <= i3_q;
    a4_q <= a3_q;
    dl4_q <= DeadW'(st3_q) + DeadW'(prod3_q[ProdW-1:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.scan_start) begin
        min_valid_q <= 1'b0;
      end else if (v4_q && a4_q && (!min_valid_q || dl4_q < min_dl_q)) begin
        min_valid_q <= 1'b1;
      end
      if (ctrl_i.take_due) begin
        pend_valid_q <= 1'b1;
      end else if (ctrl_i.out_final) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.scan_start && v4_q && a4_q && (!min_valid_q || dl4_q < min_dl_q)) begin
      min_dl_q <= dl4_q;
      min_idx_q <= i4_q;
    end
    if (ctrl_i.take_due) begin
      pend_idx_q <= min_idx_q;
    end
  end

  assign diff = min_dl_q - DeadW'(now_q);
  assign next_delay = (min_dl_q <= DeadW'(now_q)) ? '0 :
                      (|diff[DeadW-1:DelayW]) ? '1 : diff[DelayW-1:0];
  assign pend_ext = ExtW'(pend_idx_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      expired_valid_o <= pend_valid_q;
      expired_slot_o <= pend_valid_q ? pend_ext[SlotW-1:0] : '0;
      last_o <= ctrl_i.out_final;
      next_valid_o <= ctrl_i.out_final && min_valid_q;
      next_delay_us_o <= (ctrl_i.out_final && min_valid_q) ? next_delay : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.is_tick = (cmd_q == CmdTick);
  assign stat_o.scan_done = !run_q && !v1_q && !v2_q && !v3_q && !v4_q;
  assign stat_o.due = min_valid_q && (min_dl_q <= DeadW'(now_q));
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free = out_free;

endmodule

>>> hdl/scaled_timer_queue_core.sv
// Arm, disarm or quiet tick: one word loaded after one scan of the timer memory.
// A tick that expires k slots takes k + 1 scans of the timer memory; each scan
// reads one slot per cycle through a 4-stage deadline pipe.
// One item is in work at a time; the output register lets the next item enter early.
// Reset clears all armed flags and sets scale to 1.0; slot memory keeps no reset.
module scaled_timer_queue_core #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scq_pkg::ScaleW-1:0] cfg_data_i,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [scq_pkg::CmdW-1:0]   cmd_i,
  input  logic [scq_pkg::SlotW-1:0]  slot_i,
  input  logic [scq_pkg::ValueW-1:0] delay_value_i,
  input  logic [scq_pkg::TimeW-1:0]  now_us_i,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       expired_valid_o,
  output logic [scq_pkg::SlotW-1:0]  expired_slot_o,
  output logic                       last_o,
  output logic                       next_valid_o,
  output logic [scq_pkg::DelayW-1:0] next_delay_us_o
);
  import scq_pkg::*;

  logic [ScaleW-1:0] scale_q;
  scq_ctrl_t ctrl;
  scq_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleOne;
    end else if (cfg_valid) begin
      scale_q <= cfg_data_i;
    end
  end

  scq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  scq_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .scale_i         (scale_q),
    .cmd_i           (cmd_i),
    .slot_i          (slot_i),
    .delay_value_i   (delay_value_i),
    .now_us_i        (now_us_i),
    .out_stall_i     (out_stall),
    .out_valid_o     (out_valid),
    .expired_valid_o (expired_valid_o),
    .expired_slot_o  (expired_slot_o),
    .last_o          (last_o),
    .next_valid_o    (next_valid_o),
    .next_delay_us_o (next_delay_us_o)
  );

endmodule
